@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/jmfi_pkg.sv @@
`timescale 1ns / 1ps
package jmfi_pkg;
  localparam int NUM_COMP = 8;
  localparam int COMP_W = 32;
  localparam int FREQ_W = 32;
  localparam int DEPTH_DEFAULT = 256;
  localparam int COUNT_W = 9;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BELOW = 2'd1;
  localparam logic [1:0] STATUS_ABOVE = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

@@ hw/rtl/jones_matrix_freq_interpolator.sv @@
`timescale 1ns / 1ps
// Channel   | Signals                                   | Handshake
// input     | mode, entry_index, frequency, m*_real/imag | start && !busy
// config    | cfg_data                                  | cfg_valid && cfg_ready
// result    | status, out*_real/imag                    | result_strobe
// A load writes the frequency point in the accept cycle, then one component word a cycle
// into memory. A query scans the table one point at a time, then runs eight interpolations
// around the shared divider; a query outside the table skips both. Start is ignored while
// busy, so one request is handled at a time. Reset (rst, synchronous) clears control only;
// the memories are undefined until loaded. The result strobe lasts one cycle and cannot
// stall.
`include "assert_macros.svh"
module jones_matrix_freq_interpolator import jmfi_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [7:0]         entry_index,
  input  logic [31:0]        frequency,
  input  logic signed [31:0] m0_real,
  input  logic signed [31:0] m0_imag,
  input  logic signed [31:0] m1_real,
  input  logic signed [31:0] m1_imag,
  input  logic signed [31:0] m2_real,
  input  logic signed [31:0] m2_imag,
  input  logic signed [31:0] m3_real,
  input  logic signed [31:0] m3_imag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  output logic               result_strobe,
  output logic [1:0]         status,
  output logic signed [31:0] out0_real,
  output logic signed [31:0] out0_imag,
  output logic signed [31:0] out1_real,
  output logic signed [31:0] out1_imag,
  output logic signed [31:0] out2_real,
  output logic signed [31:0] out2_imag,
  output logic signed [31:0] out3_real,
  output logic signed [31:0] out3_imag
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 3;
  localparam int NW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_F0    = 4'd2;
  localparam logic [3:0] S_FL    = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_RDLO  = 4'd5;
  localparam logic [3:0] S_RDHI  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_RDF   = 4'd12;

  logic [3:0] state;

  // memories
  logic [31:0] freq_mem [TABLE_DEPTH];
  logic [31:0] comp_mem [TABLE_DEPTH*NUM_COMP];
  logic [AW-1:0] f_addr;
  logic [CW-1:0] c_addr;
  logic [31:0] f_rd;
  logic [31:0] c_rd;
  logic f_we, c_we;
  logic [31:0] c_wd;

  logic [8:0]  entry_count;
  logic [NW-1:0] n_eff;
  logic [31:0] q;
  logic [AW-1:0] ld_slot;
  logic        ld_ok;
  logic [31:0] ld_comp [NUM_COMP];
  logic [2:0]  j;
  logic [NW-1:0] k;
  logic [31:0] f_prev;
  logic [31:0] f0;
  logic [31:0] off;
  logic [31:0] gap;
  logic signed [31:0] c_lo;
  logic [32:0] mag;
  logic        neg;
  logic [63:0] prod;
  logic [31:0] res [NUM_COMP];
  logic        div_go;
  div_ctl_t    div_ctl;
  logic [63:0] div_q;

  always_comb begin
    if (entry_count < 9'd2) n_eff = NW'(2);
    else if ({23'd0, entry_count} > TABLE_DEPTH) n_eff = NW'(TABLE_DEPTH);
    else n_eff = NW'(entry_count);
  end

  always_ff @(posedge clk) begin
    if (f_we) freq_mem[f_addr] <= frequency;
    f_rd <= freq_mem[f_addr];
  end
  always_ff @(posedge clk) begin
    if (c_we) comp_mem[c_addr] <= c_wd;
    c_rd <= comp_mem[c_addr];
  end

  assign f_we = (state == S_IDLE) && start && (mode == MODE_LOAD)
                && ({24'd0, entry_index} < TABLE_DEPTH);
  assign c_we = (state == S_LOAD) && ld_ok;
  assign c_wd = ld_comp[j];

  always_comb begin
    f_addr = AW'(entry_index);
    case (state)
      S_IDLE:  f_addr = (mode == MODE_QUERY) ? '0 : AW'(entry_index);
      S_F0:    f_addr = AW'(n_eff - NW'(1));
      default: f_addr = AW'(k);
    endcase
  end

  always_comb begin
    case (state)
      S_LOAD:  c_addr = {ld_slot, j};
      // an exact hit on the first point reads that point as the lower one
      S_RDLO:  c_addr = (k == '0) ? {AW'(k), j} : {AW'(k - NW'(1)), j};
      S_RDHI:  c_addr = {AW'(k), j};
      default: c_addr = {AW'(k), j};
    endcase
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = !busy;
  // pulse once on entry; hold off while running and in the cycle that carries done
  assign div_go = (state == S_DIV) && !div_ctl.busy && !div_ctl.done;

  jmfi_divider u_div (
    .clk(clk), .rst(rst), .start(div_go),
    .dividend(prod), .divisor(gap), .ctl(div_ctl), .quotient(div_q)
  );

  logic signed [33:0] sum;
  logic [33:0] part;
  assign part = (div_q[63:33] != '0) ? 34'h1_FFFF_FFFF : {1'b0, div_q[32:0]};
  assign sum = neg ? ({{2{c_lo[31]}}, c_lo} - $signed(part))
                   : ({{2{c_lo[31]}}, c_lo} + $signed(part));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= 9'd2;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) entry_count <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            q <= frequency;
            j <= '0;
            ld_slot <= AW'(entry_index);
            ld_ok <= ({24'd0, entry_index} < TABLE_DEPTH);
            ld_comp[0] <= m0_real; ld_comp[1] <= m0_imag;
            ld_comp[2] <= m1_real; ld_comp[3] <= m1_imag;
            ld_comp[4] <= m2_real; ld_comp[5] <= m2_imag;
            ld_comp[6] <= m3_real; ld_comp[7] <= m3_imag;
            k <= '0;
            state <= (mode == MODE_LOAD) ? S_LOAD : S_F0;
          end
        end
        S_LOAD: begin
          j <= j + 3'd1;
          if (j == 3'd7) state <= S_IDLE;
        end
        S_F0: begin
          f0 <= f_rd;
          state <= S_FL;
        end
        S_FL: begin
          for (int i = 0; i < NUM_COMP; i++) res[i] <= '0;
          if (q < f0) begin
            status <= STATUS_BELOW; state <= S_DONE;
          end else if (q > f_rd) begin
            status <= STATUS_ABOVE; state <= S_DONE;
          end else begin
            status <= STATUS_OK; state <= S_RDF;
          end
        end
        S_RDF: state <= S_SCAN; // read of point k in flight
        S_SCAN: begin
          if (k < n_eff - NW'(1) && f_rd < q) begin
            f_prev <= f_rd;
            k <= k + NW'(1);
            state <= S_RDF;
          end else begin
            off <= q - f_prev;
            gap <= f_rd - f_prev;
            j <= '0;
            state <= S_RDLO;
          end
        end
        S_RDLO: state <= S_RDHI;
        S_RDHI: begin
          c_lo <= c_rd;
          state <= (k == '0) ? S_ACC : S_MUL;
        end
        S_MUL: begin
          // c_rd still holds the upper component
          mag <= ($signed(c_rd) < c_lo) ? 33'({c_lo[31], c_lo} - {c_rd[31], c_rd})
                                        : 33'({c_rd[31], c_rd} - {c_lo[31], c_lo});
          neg <= ($signed(c_rd) < c_lo);
          state <= S_WAIT;
        end
        S_WAIT: begin
          prod <= 64'(mag) * 64'(off);
          state <= S_DIV;
        end
        S_DIV: if (div_ctl.done) state <= S_ACC;
        S_ACC: begin
          if (k == '0) res[j] <= c_lo;
          else if (sum > 34'sh7FFF_FFFF) res[j] <= 32'h7FFF_FFFF;
          else if (sum < -34'sh8000_0000) res[j] <= 32'h8000_0000;
          else res[j] <= sum[31:0];
          j <= j + 3'd1;
          state <= (j == 3'd7) ? S_DONE : S_RDLO;
        end
        S_DONE: begin
          result_strobe <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out0_real = res[0];
  assign out0_imag = res[1];
  assign out1_real = res[2];
  assign out1_imag = res[3];
  assign out2_real = res[4];
  assign out2_imag = res[5];
  assign out3_real = res[6];
  assign out3_imag = res[7];

  `ASSERT_NEXT(a_strobe_one, clk, rst, result_strobe, !result_strobe)
  `ASSERT_IMPLIES(a_strobe_idle, clk, rst, result_strobe, !busy)
  `ASSERT_IMPLIES(a_div_in_div, clk, rst, div_ctl.busy, state == S_DIV)
endmodule

@@ hw/rtl/jmfi_divider.sv @@
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle: 64-bit dividend,
// 32-bit divisor, 64-bit quotient
module jmfi_divider import jmfi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output div_ctl_t    ctl,
  output logic [63:0] quotient
);
  logic [32:0] rem;
  logic [63:0] quo;
  logic [31:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
endmodule

@@ tb/sv/jones_matrix_freq_interpolator_test.sv @@
`timescale 1ns / 1ps
module jones_matrix_freq_interpolator_test;
  import jmfi_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] comp [NUM_COMP];
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               mode = MODE_LOAD;
  logic [7:0]         entry_index = '0;
  logic [31:0]        frequency = '0;
  logic signed [31:0] m_in [NUM_COMP];
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [8:0]         cfg_data = '0;
  logic               result_strobe;
  logic [1:0]         status;
  logic signed [31:0] m_out [NUM_COMP];

  // table and register copy kept by the predictor
  logic [31:0] point_freq [DEPTH];
  logic [31:0] point_comp [DEPTH][NUM_COMP];
  logic [8:0]  active_count = 9'd2;

  answer_t answers_due [$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      sent_any = 1'b0;

  initial begin
    for (int i = 0; i < NUM_COMP; i++) m_in[i] = '0;
  end

  jones_matrix_freq_interpolator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .entry_index(entry_index), .frequency(frequency),
    .m0_real(m_in[0]), .m0_imag(m_in[1]), .m1_real(m_in[2]), .m1_imag(m_in[3]),
    .m2_real(m_in[4]), .m2_imag(m_in[5]), .m3_real(m_in[6]), .m3_imag(m_in[7]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .status(status),
    .out0_real(m_out[0]), .out0_imag(m_out[1]), .out1_real(m_out[2]),
    .out1_imag(m_out[3]), .out2_real(m_out[4]), .out2_imag(m_out[5]),
    .out3_real(m_out[6]), .out3_imag(m_out[7])
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] lerp_component(logic [31:0] lo_raw, logic [31:0] hi_raw,
                                                 logic [63:0] off, logic [63:0] gap);
    longint      lo;
    longint      hi;
    longint      d;
    logic [63:0] mag;
    logic [63:0] part;
    longint      r;
    lo = longint'($signed(lo_raw));
    hi = longint'($signed(hi_raw));
    d = hi - lo;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    part = (mag * off) / gap;
    r = (d < 0) ? lo - longint'(part) : lo + longint'(part);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic answer_t interpolate(logic [31:0] q);
    answer_t a;
    int      n;
    int      k;
    n = active_count;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    a.status = STATUS_OK;
    for (int j = 0; j < NUM_COMP; j++) a.comp[j] = '0;
    if (q < point_freq[0]) begin
      a.status = STATUS_BELOW;
    end else if (q > point_freq[n-1]) begin
      a.status = STATUS_ABOVE;
    end else begin
      k = 0;
      while (k < n - 1 && point_freq[k] < q) k++;
      for (int j = 0; j < NUM_COMP; j++) begin
        if (k == 0)
          a.comp[j] = point_comp[0][j];
        else
          a.comp[j] = lerp_component(point_comp[k-1][j], point_comp[k][j],
                                     64'(q) - 64'(point_freq[k-1]),
                                     64'(point_freq[k]) - 64'(point_freq[k-1]));
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // one transaction on the command port; a gap of zero keeps start high
  task automatic send_item(logic md, logic [7:0] idx, logic [31:0] f,
                           logic [31:0] c [NUM_COMP]);
    int gap;
    gap = sent_any ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_any = 1'b1;
    start <= 1'b1;
    mode <= md;
    entry_index <= idx;
    frequency <= f;
    for (int j = 0; j < NUM_COMP; j++) m_in[j] <= c[j];
    do @(posedge clk); while (busy);
    if (md == MODE_LOAD) begin
      point_freq[idx] = f;
      for (int j = 0; j < NUM_COMP; j++) point_comp[idx][j] = c[j];
    end else begin
      answers_due.push_back(interpolate(f));
    end
  endtask

  task automatic load_point(logic [7:0] idx, logic [31:0] f);
    logic [31:0] c [NUM_COMP];
    for (int j = 0; j < NUM_COMP; j++) c[j] = $urandom();
    send_item(MODE_LOAD, idx, f, c);
  endtask

  task automatic query(logic [31:0] f);
    logic [31:0] c [NUM_COMP];
    for (int j = 0; j < NUM_COMP; j++) c[j] = $urandom();
    send_item(MODE_QUERY, $urandom_range(0, 255), f, c);
  endtask

  // hold off until every answer is in and any load has finished
  task automatic wait_drained();
    start <= 1'b0;
    sent_any = 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [8:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_count = value;
  endtask

  task automatic test_fill_table();
    logic [31:0] c [NUM_COMP];
    // spread over the full frequency range: slot 0 at zero, slot 255 at all ones
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < NUM_COMP; j++) c[j] = $urandom();
      if (i == 0) for (int j = 0; j < NUM_COMP; j++) c[j] = (j % 2) ? 32'h7FFFFFFF : 32'h80000000;
      if (i == 1) for (int j = 0; j < NUM_COMP; j++) c[j] = (j % 2) ? 32'h80000000 : 32'h7FFFFFFF;
      send_item(MODE_LOAD, i[7:0], 32'(i) * 32'h01010101, c);
    end
  endtask

  task automatic test_directed();
    write_count(9'd256);
    query(32'h0);
    query(32'hFFFFFFFF);
    query(32'h00808080);
    query(32'h00000001);
    query(32'h01010100);
    query(32'h7F7F7F80);
    query(32'hFEFEFEFF);
    write_count(9'd511);
    query(32'hFFFFFFFF);
    query(32'hAAAAAAAA);
    write_count(9'd0);
    query(32'h01010101);
    query(32'h01010102);
    query(32'hFFFFFFFF);
    write_count(9'd1);
    query(32'h00555555);
    // raise the first point so that a query can fall below it
    load_point(8'd0, 32'h00000010);
    query(32'h0);
    query(32'h0000000F);
    query(32'h00000010);
    write_count(9'd2);
    query(32'h01010101);
  endtask

  task automatic test_random(int budget);
    int          n;
    int          sent;
    logic [31:0] fs [$];
    logic [63:0] lo;
    logic [63:0] hi;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(200, 300);
        1:       n = $urandom_range(0, 1);
        default: n = $urandom_range(2, 16);
      endcase
      write_count(n[8:0]);
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      if (n <= 16) begin
        fs.delete();
        for (int i = 0; i < n; i++) fs.push_back($urandom_range(0, 3) == 0 ?
                                                 $urandom() : $urandom_range(0, 4000));
        // most tables sorted; the rest left in arbitrary order as noise
        if ($urandom_range(0, 4) != 0) fs.sort();
        for (int i = 0; i < n; i++) begin
          load_point(i[7:0], fs[i]);
          sent++;
        end
      end
      lo = point_freq[0];
      hi = point_freq[n-1];
      repeat ($urandom_range(4, 12)) begin
        case ($urandom_range(0, 9))
          0: query(lo > 0 ? $urandom_range(0, 32'(lo - 1)) : 32'h0);
          1: query(hi < 64'hFFFFFFFF ? 32'(hi + 1 + $urandom_range(0, 32'(64'hFFFFFFFF - hi - 1)))
                                      : 32'hFFFFFFFF);
          2: query(point_freq[$urandom_range(0, n - 1)]);
          3: query($urandom());
          default: query(hi >= lo ? 32'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)))
                                  : $urandom());
        endcase
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (!rst && result_strobe) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        a = answers_due.pop_front();
        if (status !== a.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, a.status));
        for (int j = 0; j < NUM_COMP; j++)
          if (m_out[j] !== a.comp[j])
            report_mismatch($sformatf("component %0d is %h, expected %h",
                                      j, m_out[j], a.comp[j]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_table();
    test_directed();
    test_random(470);
    wait_drained();
    repeat (50) @(posedge clk);
    if (answers_due.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", answers_due.size()));
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
